### hw/rtl/vau_pkg.sv
// types, constants and fixed-point helpers for the vector arithmetic unit
package vau_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int ACC_BITS  = 2 * WORD_BITS + 2;
	localparam int ADD_BITS  = WORD_BITS + 2;
	localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
	localparam int RAD_BITS  = 2 * WORD_BITS;
	localparam int ROOT_BITS = WORD_BITS;
	localparam int SREM_BITS = WORD_BITS + 3;

	localparam logic [WORD_BITS-1:0] MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] MIN_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [WORD_BITS-1:0] FX_ONE  =
		(FRAC_BITS >= WORD_BITS - 1) ? MAX_POS : (WORD_BITS'(1) << FRAC_BITS);

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_ADDS  = 4'd2,
		OP_SUBS  = 4'd3,
		OP_MULS  = 4'd4,
		OP_DIVS  = 4'd5,
		OP_DOT   = 4'd6,
		OP_CROSS = 4'd7,
		OP_MAG   = 4'd8,
		OP_SQMAG = 4'd9,
		OP_NORM  = 4'd10,
		OP_HOMOG = 4'd11
	} op_t;

	// what rides along the root and quotient stages
	typedef struct packed {
		op_t                             op;
		logic [2:0][WORD_BITS-1:0]       r;
		logic [WORD_BITS-1:0]            sc;
		logic [2:0][NUM_BITS-1:0]        num;
		logic [2:0]                      aneg;
		logic [WORD_BITS-1:0]            dmag;
		logic                            dneg;
		logic [WORD_BITS-1:0]            wpass;
	} carry_t;

	function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [ACC_BITS-1:0] v);
		logic [ACC_BITS-WORD_BITS:0] top;
		top = v[ACC_BITS-1:WORD_BITS-1];
		if (top == '0 || top == '1) return v[WORD_BITS-1:0];
		else if (v[ACC_BITS-1]) return MIN_NEG;
		else return MAX_POS;
	endfunction

	// drop the fraction, rounding toward zero
	function automatic logic signed [ACC_BITS-1:0] trunc_frac(
		input logic signed [ACC_BITS-1:0] v);
		logic signed [ACC_BITS-1:0] b;
		b = v + (v[ACC_BITS-1] ? ACC_BITS'((1 << FRAC_BITS) - 1) : ACC_BITS'(0));
		return b >>> FRAC_BITS;
	endfunction

	function automatic logic [WORD_BITS-1:0] abs_word(input logic signed [WORD_BITS-1:0] v);
		logic [WORD_BITS-1:0] m;
		m = v[WORD_BITS-1] ? WORD_BITS'(-v) : WORD_BITS'(v);
		return m;
	endfunction

	function automatic logic [WORD_BITS-1:0] sat_quot(input logic [NUM_BITS-1:0] q,
		input logic neg);
		logic [NUM_BITS-1:0] nq;
		nq = -q;
		if (!neg) return (q > NUM_BITS'(MAX_POS)) ? MAX_POS : q[WORD_BITS-1:0];
		else return (q > NUM_BITS'(MIN_NEG)) ? MIN_NEG : nq[WORD_BITS-1:0];
	endfunction

endpackage

### hw/rtl/vec3_arith_unit_top.sv
// three-component vector alu in signed fixed point, fully pipelined
//
// A request is taken on any cycle with start high; busy never rises, so a new
// request may enter every clock. Each result appears on the result ports with
// done high for one cycle, in request order; the receiver cannot hold it off.
// Each request passes through a 32-stage square-root pipeline (one root bit per
// stage) followed by 48 restoring division stages (one quotient bit per stage,
// three lanes); every opcode travels the same path.
module vec3_arith_unit_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [3:0]                          opcode,
	input  logic signed [vau_pkg::WORD_BITS-1:0] a_x,
	input  logic signed [vau_pkg::WORD_BITS-1:0] a_y,
	input  logic signed [vau_pkg::WORD_BITS-1:0] a_z,
	input  logic signed [vau_pkg::WORD_BITS-1:0] a_w,
	input  logic signed [vau_pkg::WORD_BITS-1:0] b_x,
	input  logic signed [vau_pkg::WORD_BITS-1:0] b_y,
	input  logic signed [vau_pkg::WORD_BITS-1:0] b_z,
	input  logic signed [vau_pkg::WORD_BITS-1:0] scalar_in,
	output logic                                done,
	output logic signed [vau_pkg::WORD_BITS-1:0] r_x,
	output logic signed [vau_pkg::WORD_BITS-1:0] r_y,
	output logic signed [vau_pkg::WORD_BITS-1:0] r_z,
	output logic signed [vau_pkg::WORD_BITS-1:0] r_w,
	output logic signed [vau_pkg::WORD_BITS-1:0] scalar_out,
	output logic                                div_error
);
	import vau_pkg::*;

	// valid bits
	logic                 v_s1, v_s2, v_s3;
	logic [ROOT_BITS:0]   rt_v_s;
	logic [NUM_BITS:0]    dv_v_s;
	logic                 done_q;

	// stage 1: operands
	op_t                         op_s1;
	logic signed [WORD_BITS-1:0] a_s1 [4];
	logic signed [WORD_BITS-1:0] b_s1 [3];
	logic signed [WORD_BITS-1:0] s_s1;

	// stage 2: products and component sums
	op_t                         op_s2;
	logic signed [WORD_BITS-1:0] a_s2 [4];
	logic signed [WORD_BITS-1:0] s_s2;
	logic signed [PROD_BITS-1:0] p_s2 [6];
	logic signed [ADD_BITS-1:0]  as_s2 [3];

	// stage 3: accumulations
	op_t                         op_s3;
	logic signed [WORD_BITS-1:0] a_s3 [4];
	logic signed [WORD_BITS-1:0] s_s3;
	logic signed [ACC_BITS-1:0]  acc_s3 [3];
	logic signed [ADD_BITS-1:0]  as_s3 [3];

	// square root stages
	carry_t               rt_c_s    [ROOT_BITS+1];
	logic [RAD_BITS-1:0]  rt_rad_s  [ROOT_BITS+1];
	logic [SREM_BITS-1:0] rt_rem_s  [ROOT_BITS+1];
	logic [ROOT_BITS-1:0] rt_root_s [ROOT_BITS+1];

	// division stages
	carry_t                     dv_c_s   [NUM_BITS+1];
	logic [2:0][NUM_BITS-1:0]   dv_nq_s  [NUM_BITS+1];
	logic [2:0][WORD_BITS-1:0]  dv_rem_s [NUM_BITS+1];

	// output register
	logic [WORD_BITS-1:0] rx_q, ry_q, rz_q, rw_q, sc_q;
	logic                 err_q;

	logic signed [WORD_BITS-1:0] ma [6];
	logic signed [WORD_BITS-1:0] mb [6];
	logic signed [ADD_BITS-1:0]  as_d [3];
	logic signed [ACC_BITS-1:0]  acc_d [3];
	carry_t                      c4;
	carry_t                      c_dv0;
	logic [WORD_BITS-1:0]        qv [3];
	logic [WORD_BITS-1:0]        rx_d, ry_d, rz_d, rw_d, sc_d;
	logic                        err_d;
	logic                        dz;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			rt_v_s <= '0;
			dv_v_s <= '0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			rt_v_s <= {rt_v_s[ROOT_BITS-1:0], v_s3};
			dv_v_s <= {dv_v_s[NUM_BITS-1:0], rt_v_s[ROOT_BITS]};
			done_q <= dv_v_s[NUM_BITS];
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= op_t'(opcode);
		a_s1[0] <= a_x;
		a_s1[1] <= a_y;
		a_s1[2] <= a_z;
		a_s1[3] <= a_w;
		b_s1[0] <= b_x;
		b_s1[1] <= b_y;
		b_s1[2] <= b_z;
		s_s1    <= scalar_in;
	end

	// multiplier operand selection
	always_comb begin
		ma[3] = a_s1[0];
		mb[3] = b_s1[2];
		ma[4] = a_s1[0];
		mb[4] = b_s1[1];
		ma[5] = a_s1[1];
		mb[5] = b_s1[0];
		for (int k = 0; k < 3; k++) begin
			ma[k] = a_s1[k];
			mb[k] = a_s1[k];
		end
		case (op_s1)
			OP_CROSS: begin
				ma[0] = a_s1[1];
				mb[0] = b_s1[2];
				ma[1] = a_s1[2];
				mb[1] = b_s1[1];
				ma[2] = a_s1[2];
				mb[2] = b_s1[0];
			end
			OP_DOT: begin
				for (int k = 0; k < 3; k++) mb[k] = b_s1[k];
			end
			OP_MULS: begin
				for (int k = 0; k < 3; k++) mb[k] = s_s1;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			case (op_s1) inside
				OP_SUB:  as_d[k] = ADD_BITS'(a_s1[k]) - ADD_BITS'(b_s1[k]);
				OP_ADDS: as_d[k] = ADD_BITS'(a_s1[k]) + ADD_BITS'(s_s1);
				OP_SUBS: as_d[k] = ADD_BITS'(a_s1[k]) - ADD_BITS'(s_s1);
				default: as_d[k] = ADD_BITS'(a_s1[k]) + ADD_BITS'(b_s1[k]);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		a_s2  <= a_s1;
		s_s2  <= s_s1;
		for (int k = 0; k < 6; k++) p_s2[k] <= ma[k] * mb[k];
		as_s2 <= as_d;
	end

	always_comb begin
		acc_d[0] = ACC_BITS'(p_s2[0]) + ACC_BITS'(p_s2[1]) + ACC_BITS'(p_s2[2]);
		acc_d[1] = ACC_BITS'(p_s2[1]);
		acc_d[2] = ACC_BITS'(p_s2[2]);
		case (op_s2)
			OP_CROSS: begin
				acc_d[0] = ACC_BITS'(p_s2[0]) - ACC_BITS'(p_s2[1]);
				acc_d[1] = ACC_BITS'(p_s2[2]) - ACC_BITS'(p_s2[3]);
				acc_d[2] = ACC_BITS'(p_s2[4]) - ACC_BITS'(p_s2[5]);
			end
			OP_MULS: acc_d[0] = ACC_BITS'(p_s2[0]);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		op_s3  <= op_s2;
		a_s3   <= a_s2;
		s_s3   <= s_s2;
		acc_s3 <= acc_d;
		as_s3  <= as_s2;
	end

	// finish the direct results, set up root and quotient operands
	always_comb begin
		c4       = '0;
		c4.op    = op_s3;
		c4.wpass = a_s3[3];
		for (int k = 0; k < 3; k++) begin
			c4.num[k]  = {abs_word(a_s3[k]), FRAC_BITS'(0)};
			c4.aneg[k] = a_s3[k][WORD_BITS-1];
		end
		c4.dmag = (op_s3 == OP_DIVS) ? abs_word(s_s3) : abs_word(a_s3[3]);
		c4.dneg = (op_s3 == OP_DIVS) ? s_s3[WORD_BITS-1] :
			(op_s3 == OP_HOMOG) ? a_s3[3][WORD_BITS-1] : 1'b0;
		case (op_s3) inside
			OP_ADD, OP_SUB, OP_ADDS, OP_SUBS: begin
				for (int k = 0; k < 3; k++) c4.r[k] = sat_word(ACC_BITS'(as_s3[k]));
			end
			OP_MULS, OP_CROSS: begin
				for (int k = 0; k < 3; k++) c4.r[k] = sat_word(trunc_frac(acc_s3[k]));
			end
			OP_DOT, OP_SQMAG: c4.sc = sat_word(trunc_frac(acc_s3[0]));
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rt_c_s[0]    <= c4;
		rt_rad_s[0]  <= acc_s3[0][RAD_BITS-1:0];
		rt_rem_s[0]  <= '0;
		rt_root_s[0] <= '0;
	end

	// one root bit per stage
	for (genvar i = 0; i < ROOT_BITS; i++) begin : g_rt
		logic [SREM_BITS-1:0] rem2, trial;
		logic                 ge;
		always_comb begin
			rem2  = {rt_rem_s[i][SREM_BITS-3:0], rt_rad_s[i][RAD_BITS-1 -: 2]};
			trial = {{(SREM_BITS-ROOT_BITS-2){1'b0}}, rt_root_s[i], 2'b01};
			ge    = rem2 >= trial;
		end
		always_ff @(posedge clk) begin
			rt_c_s[i+1]    <= rt_c_s[i];
			rt_rad_s[i+1]  <= rt_rad_s[i] << 2;
			rt_rem_s[i+1]  <= ge ? rem2 - trial : rem2;
			rt_root_s[i+1] <= {rt_root_s[i][ROOT_BITS-2:0], ge};
		end
	end

	always_comb begin
		c_dv0 = rt_c_s[ROOT_BITS];
		if (c_dv0.op == OP_NORM) c_dv0.dmag = rt_root_s[ROOT_BITS];
		if (c_dv0.op == OP_MAG)
			c_dv0.sc = (rt_root_s[ROOT_BITS] > MAX_POS) ? MAX_POS : rt_root_s[ROOT_BITS];
	end

	always_ff @(posedge clk) begin
		dv_c_s[0]   <= c_dv0;
		dv_nq_s[0]  <= c_dv0.num;
		dv_rem_s[0] <= '0;
	end

	// one quotient bit per stage, three lanes
	for (genvar j = 0; j < NUM_BITS; j++) begin : g_dv
		logic [2:0][WORD_BITS:0] trial, diff;
		logic [2:0]              ge;
		always_comb begin
			for (int k = 0; k < 3; k++) begin
				trial[k] = {dv_rem_s[j][k], dv_nq_s[j][k][NUM_BITS-1]};
				diff[k]  = trial[k] - {1'b0, dv_c_s[j].dmag};
				ge[k]    = trial[k] >= {1'b0, dv_c_s[j].dmag};
			end
		end
		always_ff @(posedge clk) begin
			dv_c_s[j+1] <= dv_c_s[j];
			for (int k = 0; k < 3; k++) begin
				dv_nq_s[j+1][k]  <= {dv_nq_s[j][k][NUM_BITS-2:0], ge[k]};
				dv_rem_s[j+1][k] <= ge[k] ? diff[k][WORD_BITS-1:0] : trial[k][WORD_BITS-1:0];
			end
		end
	end

	// result selection
	always_comb begin
		dz = dv_c_s[NUM_BITS].dmag == '0;
		for (int k = 0; k < 3; k++) begin
			if (dz) begin
				// divide by zero saturates toward the numerator's sign; a zero numerator gives zero
				if (dv_c_s[NUM_BITS].num[k] == '0) qv[k] = '0;
				else qv[k] = dv_c_s[NUM_BITS].aneg[k] ? MIN_NEG : MAX_POS;
			end else begin
				qv[k] = sat_quot(dv_nq_s[NUM_BITS][k],
					dv_c_s[NUM_BITS].aneg[k] ^ dv_c_s[NUM_BITS].dneg);
			end
		end
		rx_d  = '0;
		ry_d  = '0;
		rz_d  = '0;
		rw_d  = '0;
		sc_d  = '0;
		err_d = 1'b0;
		case (dv_c_s[NUM_BITS].op) inside
			OP_ADD, OP_SUB, OP_ADDS, OP_SUBS, OP_MULS, OP_CROSS: begin
				rx_d = dv_c_s[NUM_BITS].r[0];
				ry_d = dv_c_s[NUM_BITS].r[1];
				rz_d = dv_c_s[NUM_BITS].r[2];
				rw_d = FX_ONE;
			end
			OP_DIVS, OP_NORM, OP_HOMOG: begin
				rx_d  = qv[0];
				ry_d  = qv[1];
				rz_d  = qv[2];
				rw_d  = (dv_c_s[NUM_BITS].op == OP_NORM) ? dv_c_s[NUM_BITS].wpass : FX_ONE;
				err_d = dz;
			end
			OP_DOT, OP_MAG, OP_SQMAG: sc_d = dv_c_s[NUM_BITS].sc;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rx_q  <= rx_d;
		ry_q  <= ry_d;
		rz_q  <= rz_d;
		rw_q  <= rw_d;
		sc_q  <= sc_d;
		err_q <= err_d;
	end

	assign done       = done_q;
	assign r_x        = rx_q;
	assign r_y        = ry_q;
	assign r_z        = rz_q;
	assign r_w        = rw_q;
	assign scalar_out = sc_q;
	assign div_error  = err_q;

endmodule

### tb/sv/vec3_arith_unit_top_tb.sv
// testbench for the vector arithmetic unit: random and corner requests against a predictor
`timescale 1ns / 1ps

module vec3_arith_unit_top_tb;
	import vau_pkg::*;

	typedef logic signed [129:0] wide_t;

	typedef struct {
		logic [31:0] rx, ry, rz, rw, sc;
		logic        err;
	} vres_t;

	class vec_scoreboard;
		vres_t pending[$];
		int    errors;

		function new();
			errors = 0;
		endfunction

		static function logic [31:0] sat(input wide_t v);
			if (v > wide_t'(64'sh7FFF_FFFF)) return MAX_POS;
			if (v < -wide_t'(64'sh8000_0000)) return MIN_NEG;
			return v[31:0];
		endfunction

		// drop the fraction toward zero
		static function wide_t trunc(input wide_t v);
			return (v < 0) ? -((-v) >>> FRAC_BITS) : (v >>> FRAC_BITS);
		endfunction

		static function logic [31:0] quot(input wide_t num, input wide_t dmag, input logic dneg,
			inout logic err);
			wide_t q;
			logic  nneg;
			if (dmag == 0) begin
				err = 1'b1;
				return (num > 0) ? MAX_POS : (num < 0) ? MIN_NEG : 32'd0;
			end
			nneg = num < 0;
			q = ((nneg ? -num : num) <<< FRAC_BITS) / dmag;
			return sat((nneg != dneg) ? -q : q);
		endfunction

		static function wide_t isqrt(input wide_t n);
			wide_t r, c;
			r = 0;
			for (int b = 33; b >= 0; b--) begin
				c = r | (wide_t'(1) <<< b);
				if (c * c <= n) r = c;
			end
			return r;
		endfunction

		function void note(input logic [3:0] op, input logic signed [31:0] ax, ay, az, aw,
			bx, by, bz, s);
			vres_t e;
			wide_t a[3], b[3], sw, sq, m, awd;
			logic  er;
			a[0] = ax; a[1] = ay; a[2] = az;
			b[0] = bx; b[1] = by; b[2] = bz;
			sw = s; awd = aw;
			er = 1'b0;
			e = '{rx: 0, ry: 0, rz: 0, rw: FX_ONE, sc: 0, err: 0};
			sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
			m = isqrt(sq);
			case (op)
				OP_ADD: begin e.rx = sat(a[0] + b[0]); e.ry = sat(a[1] + b[1]); e.rz = sat(a[2] + b[2]); end
				OP_SUB: begin e.rx = sat(a[0] - b[0]); e.ry = sat(a[1] - b[1]); e.rz = sat(a[2] - b[2]); end
				OP_ADDS: begin e.rx = sat(a[0] + sw); e.ry = sat(a[1] + sw); e.rz = sat(a[2] + sw); end
				OP_SUBS: begin e.rx = sat(a[0] - sw); e.ry = sat(a[1] - sw); e.rz = sat(a[2] - sw); end
				OP_MULS: begin
					e.rx = sat(trunc(a[0] * sw));
					e.ry = sat(trunc(a[1] * sw));
					e.rz = sat(trunc(a[2] * sw));
				end
				OP_DIVS: begin
					e.rx = quot(a[0], (sw < 0) ? -sw : sw, sw < 0, er);
					e.ry = quot(a[1], (sw < 0) ? -sw : sw, sw < 0, er);
					e.rz = quot(a[2], (sw < 0) ? -sw : sw, sw < 0, er);
				end
				OP_DOT: begin
					e = '{rx: 0, ry: 0, rz: 0, rw: 0, sc: 0, err: 0};
					e.sc = sat(trunc(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]));
				end
				OP_CROSS: begin
					e.rx = sat(trunc(a[1] * b[2] - a[2] * b[1]));
					e.ry = sat(trunc(a[2] * b[0] - a[0] * b[2]));
					e.rz = sat(trunc(a[0] * b[1] - a[1] * b[0]));
				end
				OP_MAG: begin
					e = '{rx: 0, ry: 0, rz: 0, rw: 0, sc: 0, err: 0};
					e.sc = sat(m);
				end
				OP_SQMAG: begin
					e = '{rx: 0, ry: 0, rz: 0, rw: 0, sc: 0, err: 0};
					e.sc = sat(trunc(sq));
				end
				OP_NORM: begin
					e.rx = quot(a[0], m, 1'b0, er);
					e.ry = quot(a[1], m, 1'b0, er);
					e.rz = quot(a[2], m, 1'b0, er);
					e.rw = aw;
				end
				OP_HOMOG: begin
					e.rx = quot(a[0], (awd < 0) ? -awd : awd, awd < 0, er);
					e.ry = quot(a[1], (awd < 0) ? -awd : awd, awd < 0, er);
					e.rz = quot(a[2], (awd < 0) ? -awd : awd, awd < 0, er);
				end
				default: e = '{rx: 0, ry: 0, rz: 0, rw: 0, sc: 0, err: 0};
			endcase
			e.err = er;
			pending.push_back(e);
		endfunction

		function void check(input vres_t got);
			vres_t e;
			if (pending.size() == 0) begin
				$display("%0t: result with no request outstanding", $time);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.rx !== e.rx) begin $display("%0t: r_x exp %h got %h", $time, e.rx, got.rx); errors++; end
			if (got.ry !== e.ry) begin $display("%0t: r_y exp %h got %h", $time, e.ry, got.ry); errors++; end
			if (got.rz !== e.rz) begin $display("%0t: r_z exp %h got %h", $time, e.rz, got.rz); errors++; end
			if (got.rw !== e.rw) begin $display("%0t: r_w exp %h got %h", $time, e.rw, got.rw); errors++; end
			if (got.sc !== e.sc) begin
				$display("%0t: scalar_out exp %h got %h", $time, e.sc, got.sc);
				errors++;
			end
			if (got.err !== e.err) begin
				$display("%0t: div_error exp %b got %b", $time, e.err, got.err);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done, div_error;
	logic [3:0] opcode;
	logic signed [31:0] a_x, a_y, a_z, a_w, b_x, b_y, b_z, scalar_in;
	logic signed [31:0] r_x, r_y, r_z, r_w, scalar_out;

	vec_scoreboard sb = new();
	int idle_cycles = 0;

	vec3_arith_unit_top i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// note accepted requests and check results
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			sb.note(opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, scalar_in);
		end
		if (arst_n && done) begin
			sb.check('{rx: r_x, ry: r_y, rz: r_z, rw: r_w, sc: scalar_out, err: div_error});
		end
		if (arst_n && ((start && !busy) || done)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= 3000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 9))
			0: case ($urandom_range(0, 6))
				0: return 32'd0;
				1: return MAX_POS;
				2: return MIN_NEG;
				3: return FX_ONE;
				4: return -FX_ONE;
				5: return 32'd1;
				default: return '1;
			endcase
			1, 2, 3: return $urandom;
			default: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
		endcase
	endfunction

	task automatic send_request(input logic [3:0] op, input logic [31:0] ax, ay, az, aw,
		bx, by, bz, s);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
			($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 2));
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		a_x <= ax; a_y <= ay; a_z <= az; a_w <= aw;
		b_x <= bx; b_y <= by; b_z <= bz; scalar_in <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		logic [3:0] op;
		logic [31:0] s, aw;
		start = 1'b0; opcode = '0;
		a_x = 0; a_y = 0; a_z = 0; a_w = 0; b_x = 0; b_y = 0; b_z = 0; scalar_in = 0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner requests
		send_request(OP_ADD, MAX_POS, MIN_NEG, 0, 0, MAX_POS, MIN_NEG, 0, 0);
		send_request(OP_SUB, MAX_POS, MIN_NEG, '1, 0, MIN_NEG, MAX_POS, '1, 0);
		send_request(OP_ADDS, MAX_POS, MIN_NEG, 5, 0, 0, 0, 0, MAX_POS);
		send_request(OP_SUBS, MAX_POS, MIN_NEG, 5, 0, 0, 0, 0, MIN_NEG);
		send_request(OP_MULS, MIN_NEG, MAX_POS, -FX_ONE, 0, 0, 0, 0, MIN_NEG);
		send_request(OP_MULS, 32'h0003_0000, -32'h0000_8000, 1, 0, 0, 0, 0, -FX_ONE);
		// division by zero with positive, negative and zero numerators, then by one and by the most negative divisor
		send_request(OP_DIVS, FX_ONE, -FX_ONE, 0, 0, 0, 0, 0, 0);
		send_request(OP_DIVS, MIN_NEG, MAX_POS, 7, 0, 0, 0, 0, 1);
		send_request(OP_DIVS, MIN_NEG, MAX_POS, -7, 0, 0, 0, 0, MIN_NEG);
		send_request(OP_DOT, MIN_NEG, MIN_NEG, MIN_NEG, 0, MIN_NEG, MIN_NEG, MIN_NEG, 0);
		send_request(OP_DOT, FX_ONE, -FX_ONE, 3, 0, 5, 9, -3, 0);
		send_request(OP_CROSS, MAX_POS, MIN_NEG, MAX_POS, 0, MIN_NEG, MAX_POS, MIN_NEG, 0);
		send_request(OP_CROSS, FX_ONE, 0, 0, 0, 0, FX_ONE, 0, 0);
		send_request(OP_MAG, MIN_NEG, MIN_NEG, MIN_NEG, 0, 0, 0, 0, 0);
		send_request(OP_MAG, 0, 0, 0, 0, 0, 0, 0, 0);
		send_request(OP_SQMAG, MIN_NEG, MAX_POS, MIN_NEG, 0, 0, 0, 0, 0);
		send_request(OP_NORM, 0, 0, 0, MIN_NEG, 0, 0, 0, 0);
		send_request(OP_NORM, 32'h0003_0000, 32'h0004_0000, 0, MAX_POS, 0, 0, 0, 0);
		send_request(OP_NORM, 1, -1, 0, 3, 0, 0, 0, 0);
		send_request(OP_HOMOG, FX_ONE, -FX_ONE, 0, 0, 0, 0, 0, 0);
		send_request(OP_HOMOG, MAX_POS, MIN_NEG, 1, MIN_NEG, 0, 0, 0, 0);
		send_request(OP_HOMOG, MIN_NEG, MAX_POS, 1, 1, 0, 0, 0, 0);
		send_request(4'd12, MAX_POS, 1, 1, 1, 1, 1, 1, 0);
		send_request(4'd15, MIN_NEG, 1, 1, 0, 1, 1, 1, 0);

		repeat (1700) begin
			op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15)) :
				4'($urandom_range(0, 11));
			s = rnd_word();
			aw = rnd_word();
			// keep divisors mostly nonzero
			if (op == OP_DIVS && s == 0 && $urandom_range(0, 3) != 0) s = FX_ONE;
			if (op == OP_HOMOG && aw == 0 && $urandom_range(0, 3) != 0) aw = FX_ONE;
			send_request(op, rnd_word(), rnd_word(), rnd_word(), aw,
				rnd_word(), rnd_word(), rnd_word(), s);
		end
		start <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### files.f
hw/rtl/vau_pkg.sv
hw/rtl/vec3_arith_unit_top.sv
tb/sv/vec3_arith_unit_top_tb.sv
